/* rtl/core/fmibs_pkg.sv */
// Shared types and constants of the FM-index backward search unit.
// No dependencies.
package fmibs_pkg;

  localparam int unsigned MAX_TEXT_DEF     = 65536;
  localparam int unsigned SYMBOL_COUNT_DEF = 16;
  localparam int unsigned CP_STRIDE_DEF    = 64;

  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned SYM_W   = 4;
  localparam int unsigned OUT_W   = 17;
  // symbols packed into one BWT memory word
  localparam int unsigned LANES   = 8;
  localparam int unsigned LANE_W  = 3;
  localparam int unsigned CNT_W   = 4;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_CLEAR   = 2'd0,
    FUNC_APPEND  = 2'd1,
    FUNC_PATTERN = 2'd2,
    FUNC_QUERY   = 2'd3
  } func_e;

  typedef struct packed {
    logic              en;
    logic [LANE_W-1:0] lane;
    logic [SYM_W-1:0]  sym;
  } bwt_wr_t;

endpackage

/* rtl/core/fmibs_if.sv */
// Valid/ready channel interfaces for the search unit's input and result beats.
// Depends on fmibs_pkg.
interface fmibs_in_if;
  import fmibs_pkg::*;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [SYM_W-1:0]  symbol;
  logic              pattern_start;
  logic              pattern_end;
  modport source (output valid, func, symbol, pattern_start, pattern_end, input ready);
  modport sink   (input valid, func, symbol, pattern_start, pattern_end, output ready);
endinterface

interface fmibs_out_if;
  import fmibs_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    found;
  logic signed [OUT_W-1:0] interval_start;
  logic signed [OUT_W-1:0] interval_end;
  modport source (output valid, found, interval_start, interval_end, input ready);
  modport sink   (input valid, found, interval_start, interval_end, output ready);
endinterface

/* rtl/core/fm_index_backward_search_unit.sv */
// FM-index backward search unit: top level with the search sequencer and totals.
// Depends on fmibs_pkg, fmibs_if, fmibs_bwt_mem and fmibs_cp_mem.
//
// Input channel in_i carries items: clear, append a BWT symbol, a pattern
// symbol (fed from the pattern's last character to its first), or an
// empty-pattern query. Output channel out_o carries one result beat for a
// query or a pattern symbol marked pattern_end.
// Clear and append are taken in the idle state. A query goes straight to
// the result step. A pattern symbol that opens a search, or meets a failed
// search, is settled in the evaluate step (then the result step if marked).
// A symbol that narrows the interval runs two rank counts in turn; each
// reads one checkpoint row and scans the BWT memory one 8-symbol word per
// cycle, from the start of the checkpoint's block up to the rank position.
// One item is worked on at a time; in_i.ready is high only between items.
// A result waits in the output register while out_o.ready is low, and the
// unit holds the next result-bearing step until that register is free.
// Reset empties the text, totals and search state; no memory clearing pass
// is needed, as checkpoint row zero reads as zero by construction.
module fm_index_backward_search_unit #(
  parameter int unsigned MAX_TEXT     = fmibs_pkg::MAX_TEXT_DEF,
  parameter int unsigned SYMBOL_COUNT = fmibs_pkg::SYMBOL_COUNT_DEF,
  parameter int unsigned CP_STRIDE    = fmibs_pkg::CP_STRIDE_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  fmibs_in_if.sink    in_i,
  fmibs_out_if.source out_o
);
  import fmibs_pkg::*;

  localparam int unsigned TW      = $clog2(MAX_TEXT + 1);
  localparam int unsigned CP_ROWS = (MAX_TEXT + CP_STRIDE - 1) / CP_STRIDE;
  localparam int unsigned RW      = (CP_ROWS > 1) ? $clog2(CP_ROWS) : 1;
  localparam int unsigned LOG_SR  = $clog2(CP_STRIDE);
  localparam int unsigned WORDS   = (MAX_TEXT + LANES - 1) / LANES;
  localparam int unsigned WAW     = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned SW      = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_RSET,
    S_SCAN,
    S_EMIT
  } state_e;

  state_e                          state_q;
  logic [TW-1:0]                   len_q;
  logic [SYMBOL_COUNT-1:0][TW-1:0] tot_q, tot_d;
  logic [SYMBOL_COUNT-1:0][TW-1:0] cum_q, cum_d;
  logic [TW-1:0]                   low_q, high_q, nl_q, base_q, acc_q, pos_q, rbase_q;
  logic                            failed_q, first_q, last_q, which_q, query_q;
  logic                            issue_q, fst_q, row0_q, rd_vld_q;
  logic [SYM_W-1:0]                sym_q;
  logic [WAW-1:0]                  waddr_q, wend_q;
  logic                            out_valid_q, out_found_q;
  logic [OUT_W-1:0]                out_start_q, out_end_q;

  logic            in_acc, sym_ok_in, sym_ok_q, app_ok, cp_we;
  logic [SW-1:0]   idx_in, idx_q;
  logic [TW-1:0]   len_inc, cp_row_full, total, base, p_sel, p, row_full, row_cl, rank_val;
  logic [TW-1:0]   cp_val, n_val;
  logic [RW-1:0]   cp_raddr;
  bwt_wr_t         bwt_wr;
  logic [WAW-1:0]  bwt_raddr;
  logic [CNT_W-1:0] cnt;
  logic [SYMBOL_COUNT-1:0][TW-1:0] cp_rdata;
  logic            out_free, scan_done;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  assign sym_ok_in = 32'(in_i.symbol) < SYMBOL_COUNT;
  assign idx_in    = SW'(in_i.symbol);
  assign sym_ok_q  = 32'(sym_q) < SYMBOL_COUNT;
  assign idx_q     = SW'(sym_q);
  assign app_ok    = (32'(len_q) < MAX_TEXT) && sym_ok_in;
  assign len_inc   = len_q + TW'(1);

  // totals and cumulative smaller-symbol sums after an append
  always_comb begin
    for (int k = 0; k < SYMBOL_COUNT; k++) begin
      tot_d[k] = tot_q[k] + TW'(SW'(k) == idx_in);
      cum_d[k] = cum_q[k] + TW'(SW'(k) > idx_in);
    end
  end

  assign cp_row_full = len_inc >> LOG_SR;
  assign cp_we = in_acc && func_e'(in_i.func) == FUNC_APPEND && app_ok &&
                 ((len_inc & TW'(CP_STRIDE - 1)) == '0) &&
                 (32'(cp_row_full) < CP_ROWS);

  assign bwt_wr.en   = in_acc && func_e'(in_i.func) == FUNC_APPEND && app_ok;
  assign bwt_wr.lane = len_q[LANE_W-1:0];
  assign bwt_wr.sym  = in_i.symbol;

  assign total = sym_ok_q ? tot_q[idx_q] : '0;
  assign base  = sym_ok_q ? cum_q[idx_q] : '0;

  // rank position setup: clamp to the text, pick the checkpoint row
  assign p_sel    = which_q ? high_q : low_q;
  assign p        = (p_sel > len_q) ? len_q : p_sel;
  assign row_full = p >> LOG_SR;
  assign row_cl   = (32'(row_full) > CP_ROWS - 1) ? TW'(CP_ROWS - 1) : row_full;
  assign cp_raddr = RW'(row_cl);

  assign bwt_raddr = waddr_q;
  assign cp_val    = row0_q ? '0 : cp_rdata[idx_q];
  assign scan_done = !fst_q && !issue_q && !rd_vld_q;
  assign rank_val  = acc_q;
  assign n_val     = base_q + rank_val;

  fmibs_bwt_mem #(.WORDS(WORDS), .WAW(WAW), .TW(TW)) u_bwt_mem (
    .clk_i   (clk_i),
    .wr_i    (bwt_wr),
    .waddr_i (WAW'(len_q >> LANE_W)),
    .raddr_i (bwt_raddr),
    .sym_i   (sym_q),
    .lo_i    (rbase_q),
    .hi_i    (pos_q),
    .cnt_o   (cnt)
  );

  fmibs_cp_mem #(.CP_ROWS(CP_ROWS), .RW(RW), .SYMBOL_COUNT(SYMBOL_COUNT), .TW(TW)) u_cp_mem (
    .clk_i   (clk_i),
    .we_i    (cp_we),
    .waddr_i (RW'(cp_row_full)),
    .wdata_i (tot_d),
    .raddr_i (cp_raddr),
    .rdata_o (cp_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      tot_q       <= '0;
      cum_q       <= '0;
      low_q       <= '0;
      high_q      <= '0;
      failed_q    <= 1'b0;
      issue_q     <= 1'b0;
      fst_q       <= 1'b0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_o.ready && state_q != S_EMIT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            sym_q   <= in_i.symbol;
            first_q <= in_i.pattern_start;
            last_q  <= in_i.pattern_end;
            case (func_e'(in_i.func))
              FUNC_CLEAR: begin
                len_q    <= '0;
                tot_q    <= '0;
                cum_q    <= '0;
                low_q    <= '0;
                high_q   <= '0;
                failed_q <= 1'b0;
              end
              FUNC_APPEND: begin
                if (app_ok) begin
                  len_q <= len_inc;
                  tot_q <= tot_d;
                  cum_q <= cum_d;
                end
              end
              FUNC_QUERY: begin
                query_q <= 1'b1;
                state_q <= S_EMIT;
              end
              default: begin
                query_q <= 1'b0;
                state_q <= S_EVAL;
              end
            endcase
          end
        end
        S_EVAL: begin
          if (first_q) begin
            if (total == '0) begin
              failed_q <= 1'b1;
            end else begin
              failed_q <= 1'b0;
              low_q    <= base;
              high_q   <= base + total;
            end
            state_q <= last_q ? S_EMIT : S_IDLE;
          end else if (!failed_q && total != '0) begin
            base_q  <= base;
            which_q <= 1'b0;
            state_q <= S_RSET;
          end else begin
            if (total == '0) begin
              failed_q <= 1'b1;
            end
            state_q <= last_q ? S_EMIT : S_IDLE;
          end
        end
        S_RSET: begin
          pos_q   <= p;
          rbase_q <= row_cl << LOG_SR;
          row0_q  <= (row_cl == '0);
          waddr_q <= WAW'((row_cl << LOG_SR) >> LANE_W);
          wend_q  <= WAW'((p - TW'(1)) >> LANE_W);
          issue_q <= (p != (row_cl << LOG_SR));
          fst_q   <= 1'b1;
          state_q <= S_SCAN;
        end
        S_SCAN: begin
          fst_q    <= 1'b0;
          rd_vld_q <= issue_q;
          if (issue_q) begin
            waddr_q <= waddr_q + WAW'(1);
            if (waddr_q == wend_q) begin
              issue_q <= 1'b0;
            end
          end
          if (fst_q) begin
            acc_q <= cp_val;
          end else if (rd_vld_q) begin
            acc_q <= acc_q + TW'(cnt);
          end
          if (scan_done) begin
            if (!which_q) begin
              nl_q    <= n_val;
              which_q <= 1'b1;
              state_q <= S_RSET;
            end else begin
              if (nl_q >= n_val) begin
                failed_q <= 1'b1;
              end else begin
                low_q  <= nl_q;
                high_q <= n_val;
              end
              state_q <= last_q ? S_EMIT : S_IDLE;
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            if (query_q) begin
              out_found_q <= 1'b1;
              out_start_q <= '0;
              out_end_q   <= OUT_W'(len_q) - OUT_W'(1);
            end else if (failed_q) begin
              out_found_q <= 1'b0;
              out_start_q <= '1;
              out_end_q   <= '1;
            end else begin
              out_found_q <= 1'b1;
              out_start_q <= OUT_W'(low_q);
              out_end_q   <= OUT_W'(high_q) - OUT_W'(1);
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.found          = out_found_q;
  assign out_o.interval_start = out_start_q;
  assign out_o.interval_end   = out_end_q;

endmodule

/* rtl/core/fmibs_bwt_mem.sv */
// BWT symbol memory, eight symbols to a word, with a per-word match counter.
// Depends on fmibs_pkg.
module fmibs_bwt_mem #(
  parameter int unsigned WORDS = 8192,
  parameter int unsigned WAW   = 13,
  parameter int unsigned TW    = 17
) (
  input  logic                         clk_i,
  input  fmibs_pkg::bwt_wr_t           wr_i,
  input  logic [WAW-1:0]               waddr_i,
  input  logic [WAW-1:0]               raddr_i,
  input  logic [fmibs_pkg::SYM_W-1:0]  sym_i,
  input  logic [TW-1:0]                lo_i,
  input  logic [TW-1:0]                hi_i,
  output logic [fmibs_pkg::CNT_W-1:0]  cnt_o
);
  import fmibs_pkg::*;

  logic [LANES-1:0][SYM_W-1:0] mem [WORDS];
  logic [LANES-1:0][SYM_W-1:0] rdata_q;
  logic [WAW-1:0]              raddr_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[waddr_i][wr_i.lane] <= wr_i.sym;
    end
    rdata_q <= mem[raddr_i];
    raddr_q <= raddr_i;
  end

  // count lanes of the returned word that lie in [lo, hi) and match
  always_comb begin
    logic [TW-1:0] idx;
    cnt_o = '0;
    for (int j = 0; j < LANES; j++) begin
      idx = TW'({raddr_q, LANE_W'(j)});
      if (idx >= lo_i && idx < hi_i && rdata_q[j] == sym_i) begin
        cnt_o = cnt_o + CNT_W'(1);
      end
    end
  end

endmodule

/* rtl/core/fmibs_cp_mem.sv */
// Rank checkpoint memory: one row of per-symbol totals for each sample block.
// Depends on fmibs_pkg only through the instantiating module's widths.
module fmibs_cp_mem #(
  parameter int unsigned CP_ROWS      = 1024,
  parameter int unsigned RW           = 10,
  parameter int unsigned SYMBOL_COUNT = 16,
  parameter int unsigned TW           = 17
) (
  input  logic                              clk_i,
  input  logic                              we_i,
  input  logic [RW-1:0]                     waddr_i,
  input  logic [SYMBOL_COUNT-1:0][TW-1:0]   wdata_i,
  input  logic [RW-1:0]                     raddr_i,
  output logic [SYMBOL_COUNT-1:0][TW-1:0]   rdata_o
);

  logic [SYMBOL_COUNT-1:0][TW-1:0] mem [CP_ROWS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

/* rtl/core/fmibs_checker.sv */
// Port-level checks for the FM-index backward search unit, bound to the top.
// Depends on fmibs_pkg and fm_index_backward_search_unit.
module fmibs_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               out_valid_i,
  input logic                               out_ready_i,
  input logic                               found_i,
  input logic [fmibs_pkg::OUT_W-1:0]        start_i,
  input logic [fmibs_pkg::OUT_W-1:0]        end_i
);
  import fmibs_pkg::*;

  // a stalled result beat stays valid with its bounds held
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(start_i) && $stable(end_i))
    else $error("result beat dropped or changed while stalled");

  // not-found beats carry -1 bounds
  a_miss_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !found_i |-> start_i == '1 && end_i == '1)
    else $error("not-found beat without -1 bounds");

  // found beats start at a real row
  a_hit_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && found_i |-> !start_i[OUT_W-1])
    else $error("found beat with negative start");

endmodule

bind fm_index_backward_search_unit fmibs_checker u_fmibs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .found_i     (out_o.found),
  .start_i     (out_o.interval_start),
  .end_i       (out_o.interval_end)
);
